// ===== design/angle_position_pid_loop_macros.svh =====
// Assertion macros shared by the checker of angle_position_pid_loop.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ANGLE_POSITION_PID_LOOP_MACROS_SVH
`define ANGLE_POSITION_PID_LOOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define APPL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define APPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/appl_pkg.sv =====
// Package of the angle position PID loop: widths, defaults, register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package appl_pkg;

  localparam int ENCODER_BITS_DEF   = 14;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int ENC_W      = 14;  // encoder_count and angle registers
  localparam int GAIN_W     = 24;
  localparam int LIM_W      = 16;
  localparam int CUR_W      = 16;
  localparam int LIMIT_MAX  = 16384;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_OUTPUT_LOW   = 3'd3,
    CFG_OUTPUT_HIGH  = 3'd4,
    CFG_TARGET_ANGLE = 3'd5,
    CFG_ZERO_ANGLE   = 3'd6,
    CFG_REVERSE_DIR  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ENC_W-1:0] target_angle;
    logic [ENC_W-1:0] zero_angle;
    logic             reverse_dir;
  } angle_cfg_t;

endpackage

`default_nettype wire

// ===== design/appl_angle_err.sv =====
// Angle error: direction, zero offset, half-turn wrap and +/-60 degree clamp.
// Depends on appl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module appl_angle_err #(
  parameter int ENCODER_BITS = appl_pkg::ENCODER_BITS_DEF
) (
  input  appl_pkg::angle_cfg_t             cfg_i,
  input  logic [appl_pkg::ENC_W-1:0]       count_i,
  output logic signed [ENCODER_BITS-2:0]   err_o
);

  localparam int E    = ENCODER_BITS;
  localparam int CW   = (E > appl_pkg::ENC_W) ? E : appl_pkg::ENC_W;
  localparam int TURN = 2 ** E;
  localparam logic signed [E+1:0] HALF_S  = (E+2)'(TURN / 2);
  localparam logic signed [E+1:0] TURN_S  = (E+2)'(TURN);
  localparam logic signed [E+1:0] LIMIT_S = (E+2)'((TURN + 3) / 6);

  logic [CW-1:0]          cnt_w, tgt_w, zero_w;
  logic [E-1:0]           cnt, cnt_dir, rel;
  logic signed [E+1:0]    raw, wrapped, clamped;

  // Fields are 14 bits; the turn is E bits, so widen then cut.
  assign cnt_w  = CW'(count_i);
  assign tgt_w  = CW'(cfg_i.target_angle);
  assign zero_w = CW'(cfg_i.zero_angle);

  assign cnt     = cnt_w[E-1:0];
  assign cnt_dir = cfg_i.reverse_dir ? (E'(0) - cnt) : cnt;
  assign rel     = cnt_dir - zero_w[E-1:0];
  assign raw     = $signed({2'b00, tgt_w[E-1:0]}) - $signed({2'b00, rel});

  // exactly half a turn keeps its sign
  always_comb begin
    if (raw > HALF_S) begin
      wrapped = raw - TURN_S;
    end else if (raw < -HALF_S) begin
      wrapped = raw + TURN_S;
    end else begin
      wrapped = raw;
    end
    if (wrapped > LIMIT_S) begin
      clamped = LIMIT_S;
    end else if (wrapped < -LIMIT_S) begin
      clamped = -LIMIT_S;
    end else begin
      clamped = wrapped;
    end
  end

  assign err_o = clamped[E-2:0];

endmodule

`default_nettype wire

// ===== design/angle_position_pid_loop.sv =====
// Top level of the angle position PID loop: config registers, pipeline, PID.
// Depends on appl_pkg and appl_angle_err.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, encoder_count_i  | sink
//  out     | out_valid_o, out_ready_i, current_ref_o  | source
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | sink, write only
//
// One item per cycle sustained while the result is not stalled; five register
// stages, from the input register through to the output register.
// Stages: input reg, angle error, three gain multiplies, integrator and P+D
// add, final add / round / clamp into the output register.
// Reset clears the valid bits, integrator and previous error; config
// registers take their documented defaults.
// A stalled result freezes every stage together, so ready drops only then.
`timescale 1ns / 1ps
`default_nettype none

module angle_position_pid_loop #(
  parameter int ENCODER_BITS   = appl_pkg::ENCODER_BITS_DEF,
  parameter int GAIN_FRAC_BITS = appl_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [appl_pkg::ENC_W-1:0]          encoder_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [appl_pkg::CUR_W-1:0]   current_ref_o,
  input  logic                                cfg_we_i,
  input  logic [appl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [appl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int E   = ENCODER_BITS;
  localparam int F   = GAIN_FRAC_BITS;
  localparam int GW  = appl_pkg::GAIN_W;
  localparam int EW  = E - 1;            // clamped error
  localparam int DW  = E;                // error change
  localparam int IW  = F + 16;           // integrator
  localparam int PA  = E + 23;
  localparam int PB  = F + 15;
  localparam int SW  = ((PA > PB) ? PA : PB) + 2;  // accumulation width
  localparam int LW  = appl_pkg::LIM_W + 1;         // saturated limit

  // ---------------- configuration registers ----------------
  logic signed [GW-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
  logic signed [appl_pkg::LIM_W-1:0] output_low_q, output_high_q;
  appl_pkg::angle_cfg_t  angle_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      integ_gain_q  <= '0;
      deriv_gain_q  <= '0;
      output_low_q  <= -(appl_pkg::LIM_W)'(appl_pkg::LIMIT_MAX);
      output_high_q <= (appl_pkg::LIM_W)'(appl_pkg::LIMIT_MAX);
      angle_cfg_q   <= '0;
    end else if (cfg_we_i) begin
      case (appl_pkg::cfg_idx_e'(cfg_idx_i))
        appl_pkg::CFG_PROP_GAIN:    prop_gain_q   <= cfg_data_i;
        appl_pkg::CFG_INTEG_GAIN:   integ_gain_q  <= cfg_data_i;
        appl_pkg::CFG_DERIV_GAIN:   deriv_gain_q  <= cfg_data_i;
        appl_pkg::CFG_OUTPUT_LOW:   output_low_q  <= cfg_data_i[appl_pkg::LIM_W-1:0];
        appl_pkg::CFG_OUTPUT_HIGH:  output_high_q <= cfg_data_i[appl_pkg::LIM_W-1:0];
        appl_pkg::CFG_TARGET_ANGLE: angle_cfg_q.target_angle <= cfg_data_i[appl_pkg::ENC_W-1:0];
        appl_pkg::CFG_ZERO_ANGLE:   angle_cfg_q.zero_angle   <= cfg_data_i[appl_pkg::ENC_W-1:0];
        appl_pkg::CFG_REVERSE_DIR:  angle_cfg_q.reverse_dir  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Limits saturated to +/-4 A
  localparam logic signed [LW-1:0] LIM_MAX_S = LW'(appl_pkg::LIMIT_MAX);
  logic signed [LW-1:0] low_ext, high_ext, lim_lo, lim_hi;

  assign low_ext  = LW'(output_low_q);
  assign high_ext = LW'(output_high_q);

  always_comb begin
    lim_lo = low_ext;
    if (low_ext > LIM_MAX_S)  lim_lo = LIM_MAX_S;
    if (low_ext < -LIM_MAX_S) lim_lo = -LIM_MAX_S;
    lim_hi = high_ext;
    if (high_ext > LIM_MAX_S)  lim_hi = LIM_MAX_S;
    if (high_ext < -LIM_MAX_S) lim_hi = -LIM_MAX_S;
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [appl_pkg::ENC_W-1:0] enc_q;

  always_ff @(posedge clk_i) begin
    if (adv) enc_q <= encoder_count_i;
  end

  // ---------------- stage 2: angle error ----------------
  logic signed [EW-1:0] err_d, err_q;

  appl_angle_err #(
    .ENCODER_BITS(ENCODER_BITS)
  ) u_angle_err (
    .cfg_i   (angle_cfg_q),
    .count_i (enc_q),
    .err_o   (err_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv) err_q <= err_d;
  end

  // ---------------- stage 3: gain products ----------------
  logic signed [EW-1:0]    prev_q;
  logic signed [DW-1:0]    derr;
  logic signed [GW+EW-1:0] pe_q, ie_q;
  logic signed [GW+DW-1:0] de_q;

  assign derr = DW'(err_q) - DW'(prev_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pe_q <= GW'(prop_gain_q) * (GW+EW)'(err_q);
      ie_q <= (GW+EW)'(integ_gain_q) * (GW+EW)'(err_q);
      de_q <= (GW+DW)'(deriv_gain_q) * (GW+DW)'(derr);
    end
  end

  // error history advances with each item leaving the error stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (adv && v2_q) begin
      prev_q <= err_q;
    end
  end

  // ---------------- stage 4: integrator with anti-windup ----------------
  logic signed [IW-1:0] integ_q, integ_d;
  logic signed [SW-1:0] integ_sum, int_lo, int_hi, ppd_q;

  assign int_lo    = SW'(lim_lo) <<< F;
  assign int_hi    = SW'(lim_hi) <<< F;
  assign integ_sum = SW'(integ_q) + SW'(ie_q);

  // high limit wins when the limits cross
  always_comb begin
    if (integ_sum > int_hi) begin
      integ_d = int_hi[IW-1:0];
    end else if (integ_sum < int_lo) begin
      integ_d = int_lo[IW-1:0];
    end else begin
      integ_d = integ_sum[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (adv && v3_q) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) ppd_q <= SW'(pe_q) + SW'(de_q);
  end

  // ---------------- stage 5: sum, round, clamp ----------------
  localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (F - 1);

  logic signed [SW-1:0] total, cur_raw, out_lo, out_hi;
  logic signed [appl_pkg::CUR_W-1:0] cur_d, current_ref_q;

  // integ_q here already holds the value for the item in stage 4
  assign total   = ppd_q + SW'(integ_q) + HALF_LSB;
  assign cur_raw = total >>> F;
  assign out_lo  = SW'(lim_lo);
  assign out_hi  = SW'(lim_hi);

  always_comb begin
    if (cur_raw > out_hi) begin
      cur_d = out_hi[appl_pkg::CUR_W-1:0];
    end else if (cur_raw < out_lo) begin
      cur_d = out_lo[appl_pkg::CUR_W-1:0];
    end else begin
      cur_d = cur_raw[appl_pkg::CUR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) current_ref_q <= cur_d;
  end

  assign out_valid_o   = out_valid_q;
  assign current_ref_o = current_ref_q;

endmodule

`default_nettype wire

// ===== design/appl_checker.sv =====
// Port-level checker of angle_position_pid_loop and its bind.
// Depends on appl_pkg and angle_position_pid_loop_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "angle_position_pid_loop_macros.svh"

module appl_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_ready_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [appl_pkg::CUR_W-1:0]   current_ref_o
);

  localparam logic signed [appl_pkg::CUR_W-1:0] LIM =
    (appl_pkg::CUR_W)'(appl_pkg::LIMIT_MAX);

  // a stalled item stays offered and unchanged
  `APPL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `APPL_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(current_ref_o), "result changed while stalled")
  // an offered current never leaves +/-4 A whatever the limit registers hold
  `APPL_ASSERT_IMPL(a_cur_range, out_valid_o, (current_ref_o <= LIM) && (current_ref_o >= -LIM), "current outside 4 A")
  // input side only waits on a blocked result
  `APPL_ASSERT_IMPL(a_ready, !out_valid_o || out_ready_i, in_ready_o, "input held off without a stalled result")

endmodule

bind angle_position_pid_loop appl_checker u_appl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .current_ref_o (current_ref_o)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for angle_position_pid_loop: a directed table, then random phases.
// Each current reference is checked against an in-bench model of the position loop.
// Depends on appl_pkg and the angle_position_pid_loop RTL.

module tb;
  import appl_pkg::*;

  localparam int     MAX_GAP      = 11;  // longest sender gap and receiver stall
  localparam int     RESET_CYCLES = 10;
  localparam int     DRAIN_PAUSE  = 8;   // pipeline is five deep, a little margin
  localparam int     NUM_PHASES   = 8;
  localparam int     PHASE_ITEMS  = 210;
  localparam longint TIMEOUT_NS   = 10_000_000;

  // Loop arithmetic at the default parameters
  localparam int     FRAC_BITS = GAIN_FRAC_BITS_DEF;
  localparam longint TURN      = longint'(1) << ENC_W;
  localparam longint HALF_TURN = TURN / 2;
  localparam longint ERR_LIMIT = (TURN + 3) / 6;  // 60 degrees, 2731 counts
  localparam longint FRAC_ONE  = longint'(1) << FRAC_BITS;

  typedef enum logic {ROW_WRITE, ROW_COUNT} row_kind_e;

  // One directed step: either a register write or an encoder sample. Where the
  // result is obvious it is typed in; otherwise the loop model supplies it.
  typedef struct packed {
    row_kind_e               kind;
    cfg_idx_e                idx;
    logic [CFG_DATA_W-1:0]   data;
    logic [ENC_W-1:0]        count;
    logic                    known;
    logic signed [CUR_W-1:0] current;
  } directed_row_t;

  localparam int NUM_ROWS = 38;

  directed_row_t directed_rows [NUM_ROWS] = '{
    // after reset every gain is zero
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd0,     1'b1, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd16383, 1'b1, 16'sd0},
    // largest positive P gain, target at zero
    '{ROW_WRITE, CFG_PROP_GAIN,    24'h7FFFFF, 14'd0,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd0,     1'b1, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd16383, 1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd8192,  1'b1, -16'sd16384},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd1000,  1'b1, -16'sd16384},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd15000, 1'b1, 16'sd16384},
    // target written with bits above one turn; error of exactly half a turn
    '{ROW_WRITE, CFG_TARGET_ANGLE, 24'hFFE000, 14'd0,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd0,     1'b1, 16'sd16384},
    '{ROW_WRITE, CFG_PROP_GAIN,    24'h800000, 14'd0,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd0,     1'b1, -16'sd16384},
    // limits beyond 4 A saturate back to 4 A
    '{ROW_WRITE, CFG_OUTPUT_LOW,   24'hFF8000, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_OUTPUT_HIGH,  24'h007FFF, 14'd0,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd16383, 1'b1, 16'sd16384},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd8192,  1'b1, 16'sd0},
    // reversed direction, then a zero offset at the top of the turn
    '{ROW_WRITE, CFG_REVERSE_DIR,  24'hFFFFFF, 14'd0,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd1,     1'b1, 16'sd16384},
    '{ROW_WRITE, CFG_ZERO_ANGLE,   24'hFFFFFF, 14'd0,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd1,     1'b1, -16'sd16384},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd0,     1'b1, -16'sd16384},
    // integral and derivative at their extremes, windup clamp
    '{ROW_WRITE, CFG_PROP_GAIN,    24'h000000, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_INTEG_GAIN,   24'h7FFFFF, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_DERIV_GAIN,   24'h800000, 14'd0,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd16300, 1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd8000,  1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd12345, 1'b0, 16'sd0},
    // crossed limits: the integral flips between the two bounds
    '{ROW_WRITE, CFG_INTEG_GAIN,   24'h000000, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_DERIV_GAIN,   24'h000000, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_OUTPUT_LOW,   24'h000064, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_OUTPUT_HIGH,  24'h00FF9C, 14'd0,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd5,     1'b0, 16'sd0},
    '{ROW_COUNT, CFG_PROP_GAIN,    24'h000000, 14'd5,     1'b0, 16'sd0},
    // back to the reset settings
    '{ROW_WRITE, CFG_OUTPUT_LOW,   24'h00C000, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_OUTPUT_HIGH,  24'h004000, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_TARGET_ANGLE, 24'h000000, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_ZERO_ANGLE,   24'h000000, 14'd0,     1'b0, 16'sd0},
    '{ROW_WRITE, CFG_REVERSE_DIR,  24'h000000, 14'd0,     1'b0, 16'sd0}
  };

  // DUT connections, all inputs known from time zero
  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic [ENC_W-1:0]        encoder_count = '0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic signed [CUR_W-1:0] current_ref;
  logic                    cfg_we        = 1'b0;
  cfg_idx_e                cfg_idx       = CFG_PROP_GAIN;
  logic [CFG_DATA_W-1:0]   cfg_data      = '0;

  // Loop model: register copies and the two pieces of state
  longint           prop_k     = 0;
  longint           integ_k    = 0;
  longint           deriv_k    = 0;
  longint           lim_low    = -LIMIT_MAX;
  longint           lim_high   = LIMIT_MAX;
  logic [ENC_W-1:0] target_q   = '0;
  logic [ENC_W-1:0] zero_q     = '0;
  logic             reverse_q  = 1'b0;
  longint           integ_acc  = 0;
  longint           last_error = 0;

  logic signed [CUR_W-1:0] expected_current [$];

  bit in_gaps_on      = 1'b1;
  bit out_gaps_on     = 1'b1;
  bit items_in_flight = 1'b0;
  int mismatch_count  = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int writes_done     = 0;

  angle_position_pid_loop dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .encoder_count_i (encoder_count),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .current_ref_o   (current_ref),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always #10 clk = ~clk;

  // Upper bound tested first, so crossed limits resolve towards high
  function automatic longint clamp_hi_first(input longint v, input longint lo,
                                            input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One control tick of the position loop; updates integral and last error
  function automatic logic signed [CUR_W-1:0] step_position_loop(
      input logic [ENC_W-1:0] count);
    logic [ENC_W-1:0] cnt;
    logic [ENC_W-1:0] rel;
    longint           err;
    longint           lo;
    longint           hi;
    longint           acc;
    longint           cur;
    cnt = reverse_q ? ENC_W'(0) - count : count;
    rel = cnt - zero_q;  // wraps modulo one turn
    err = longint'(target_q) - longint'(rel);
    // a half-turn error stays positive
    if (err > HALF_TURN) err -= TURN;
    else if (err < -HALF_TURN) err += TURN;
    err = clamp_hi_first(err, -ERR_LIMIT, ERR_LIMIT);
    lo  = clamp_hi_first(lim_low, -LIMIT_MAX, LIMIT_MAX);
    hi  = clamp_hi_first(lim_high, -LIMIT_MAX, LIMIT_MAX);
    integ_acc = clamp_hi_first(integ_acc + integ_k * err, lo * FRAC_ONE, hi * FRAC_ONE);
    acc = prop_k * err + integ_acc + deriv_k * (err - last_error);
    cur = clamp_hi_first((acc + FRAC_ONE / 2) >>> FRAC_BITS, lo, hi);  // round half up
    last_error = err;
    return cur[CUR_W-1:0];
  endfunction

  // Mostly gains that keep the output off the rails, now and then the extremes
  function automatic logic [CFG_DATA_W-1:0] draw_gain(input int unsigned mag_bits);
    int mag;
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'(24'h7FFFFF);
      1: return CFG_DATA_W'(24'h800000);
      2: return CFG_DATA_W'($urandom);
      default: begin
        mag = int'($urandom_range(0, 1 << mag_bits));
        return ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(-mag) : CFG_DATA_W'(mag);
      end
    endcase
  endfunction

  // Leaves cfg_we high; the next sample lowers it, so back-to-back writes are
  // never lowered and raised in one step.
  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_PROP_GAIN:    prop_k    = longint'($signed(data[GAIN_W-1:0]));
      CFG_INTEG_GAIN:   integ_k   = longint'($signed(data[GAIN_W-1:0]));
      CFG_DERIV_GAIN:   deriv_k   = longint'($signed(data[GAIN_W-1:0]));
      CFG_OUTPUT_LOW:   lim_low   = longint'($signed(data[LIM_W-1:0]));
      CFG_OUTPUT_HIGH:  lim_high  = longint'($signed(data[LIM_W-1:0]));
      CFG_TARGET_ANGLE: target_q  = data[ENC_W-1:0];
      CFG_ZERO_ANGLE:   zero_q    = data[ENC_W-1:0];
      CFG_REVERSE_DIR:  reverse_q = data[0];
      default: ;
    endcase
    writes_done++;
    @(posedge clk);
  endtask

  // Presents one encoder sample and returns at the edge that takes it
  task automatic send_sample(input logic [ENC_W-1:0] count, input logic known,
                             input logic signed [CUR_W-1:0] current);
    int unsigned             gap;
    logic signed [CUR_W-1:0] predicted;
    gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    cfg_we <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    encoder_count <= count;
    predicted = step_position_loop(count);
    expected_current.push_back(known ? current : predicted);
    items_in_flight = 1'b1;
    samples_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds off the sender until every result is back, then lets the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_current.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    items_in_flight = 1'b0;
  endtask

  // Result side: random stall per item, then compare with the oldest prediction
  initial begin : result_sink
    int unsigned             stall;
    logic signed [CUR_W-1:0] want;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_current.size() == 0) begin
        $error("current_ref: expected nothing, actual %0d", current_ref);
        mismatch_count++;
      end else begin
        want = expected_current.pop_front();
        if (current_ref !== want) begin
          $error("current_ref: expected %0d, actual %0d", want, current_ref);
          mismatch_count++;
        end
        results_checked++;
      end
    end
  end

  // Stimulus: reset, directed table, random phases, final drain
  initial begin : stimulus
    int               lo_v;
    int               hi_v;
    int               a;
    int               b;
    logic [ENC_W-1:0] aim;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        if (items_in_flight) drain_results();
        write_register(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        send_sample(directed_rows[r].count, directed_rows[r].known,
                    directed_rows[r].current);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      // some phases run one side or both flat out
      in_gaps_on  = (phase % 3) != 0;
      out_gaps_on = (phase % 4) != 2;

      write_register(CFG_PROP_GAIN,  draw_gain(18));
      write_register(CFG_INTEG_GAIN, draw_gain(12));
      write_register(CFG_DERIV_GAIN, draw_gain(18));
      case ($urandom_range(0, 7))
        0: begin  // anything the 16-bit fields hold, beyond 4 A or crossed
          lo_v = int'($urandom_range(0, 65535)) - 32768;
          hi_v = int'($urandom_range(0, 65535)) - 32768;
        end
        1: begin  // crossed
          lo_v = int'($urandom_range(0, LIMIT_MAX));
          hi_v = -int'($urandom_range(0, LIMIT_MAX));
        end
        2: begin
          lo_v = -LIMIT_MAX;
          hi_v = LIMIT_MAX;
        end
        default: begin
          a = int'($urandom_range(0, 2 * LIMIT_MAX)) - LIMIT_MAX;
          b = int'($urandom_range(0, 2 * LIMIT_MAX)) - LIMIT_MAX;
          lo_v = (a < b) ? a : b;
          hi_v = (a < b) ? b : a;
        end
      endcase
      write_register(CFG_OUTPUT_LOW,   CFG_DATA_W'(lo_v));
      write_register(CFG_OUTPUT_HIGH,  CFG_DATA_W'(hi_v));
      write_register(CFG_TARGET_ANGLE, CFG_DATA_W'($urandom));
      write_register(CFG_ZERO_ANGLE,   CFG_DATA_W'($urandom));
      write_register(CFG_REVERSE_DIR,  CFG_DATA_W'($urandom));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly samples near the set point so the PID leaves the rails;
        // some half a turn away, some anywhere on the turn
        aim = target_q + zero_q + ENC_W'($urandom_range(0, 400)) - ENC_W'(200);
        case ($urandom_range(0, 9))
          0, 1: aim = ENC_W'($urandom);
          2:    aim = aim + ENC_W'(HALF_TURN);
          default: ;
        endcase
        if (reverse_q && aim != 0) aim = ENC_W'(0) - aim;
        send_sample(aim, 1'b0, '0);
        if ($urandom_range(0, 63) == 0) drain_results();
      end
    end

    drain_results();
    $display("Position loop: %0d encoder samples, %0d current references checked, %0d writes.",
             samples_sent, results_checked, writes_done);
    $display("Covered both directions, crossed and out-of-range limits, half-turn errors.");
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Hard stop in case the pipe hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/appl_pkg.sv
design/appl_angle_err.sv
design/angle_position_pid_loop.sv
design/appl_checker.sv
tb/sv/tb.sv
